[rtl/lzwd_pkg.sv]
// Shared constants for the LZSS history-window decoder
`timescale 1ns / 1ps

package lzwd_pkg;

  // token phase codes
  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // longest match, also sets where the write position starts
  localparam int MAX_MATCH = 18;

  // shortest match, added to the length code
  localparam logic [4:0] MATCH_MIN = 5'd3;

  // marker bits kept above a fresh flag byte
  localparam logic [15:0] FLAG_FILL = 16'hFF00;

endpackage

[rtl/lzss_window_decoder.sv]
// LZSS decoder top level with a sliding history window kept in one synchronous RAM
`timescale 1ns / 1ps
//
//  channel | ports                              | width | contents
//  --------+------------------------------------+-------+-------------------------------
//  input   | in_tvalid in_tready in_tdata       | 8     | compressed byte
//  output  | out_tvalid out_tready out_tdata    | 8     | decoded byte
//          | out_tlast out_tuser                | 1 + 1 | last of run, stream done
//  config  | cfg_valid cfg_ready cfg_data       | 32    | output length in bytes
//
//  A match's second byte starts the copy of its 3 to 18 bytes: a first window
//  read, then one byte a cycle through the single RAM read port while the
//  output is free. After reset every window RAM entry is cleared, one a cycle,
//  while no input is taken; configuration writes are taken throughout.
//  A stalled output holds the copy loop; the input waits only when a byte must go out.

module lzss_window_decoder #(
  parameter int WINDOW_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // compressed stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // decoded stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // [0] stream_done
  // output length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  import lzwd_pkg::*;

  localparam int          AW      = $clog2(WINDOW_SIZE);
  localparam logic [15:0] WIN16   = 16'(WINDOW_SIZE);
  localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_SIZE - 1);
  localparam logic [AW-1:0] WP_INIT  = AW'(WINDOW_SIZE - MAX_MATCH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY
  } state_t;

  // reduce a 12-bit offset modulo the window size, quotient below 16
  function automatic logic [AW-1:0] win_mod(input logic [11:0] v);
    logic [15:0] r;
    logic [15:0] step;
    r = {4'b0, v};
    for (int i = 3; i >= 0; i--) begin
      step = WIN16 << i;
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[AW-1:0];
  endfunction

  // advance a window address with wrap
  function automatic logic [AW-1:0] win_inc(input logic [AW-1:0] a);
    return (a == WIN_LAST) ? '0 : a + 1'b1;
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [15:0]     flag_shift_r, flag_shift_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      off_low_r, off_low_nxt;
  logic [31:0]     remain_r, remain_nxt;
  logic            finished_r, finished_nxt;
  logic [4:0]      copy_left_r, copy_left_nxt;
  logic            fwd_r, fwd_nxt;
  logic [7:0]      fwd_data_r, fwd_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_done_r, out_done_nxt;

  logic [7:0]      rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [7:0]      mem_wd;
  logic            rd_en;
  logic [AW-1:0]   mem_ra;

  logic            out_free;
  logic [7:0]      copy_byte;
  logic [31:0]     rem_dec;
  logic            done_now;
  logic [15:0]     flag_sh;
  logic            lit_emit;
  logic            copy_end;

  logic [7:0]      window_mem [WINDOW_SIZE];

  assign out_free  = !out_valid_r || out_tready;
  assign copy_byte = fwd_r ? fwd_data_r : rd_data_r;
  assign rem_dec   = remain_r - 32'd1;
  assign done_now  = (rem_dec == 32'd0);
  assign flag_sh   = flag_shift_r >> 1;
  assign lit_emit  = !finished_r && (phase_r == PH_FIRST) && flag_shift_r[0];
  assign copy_end  = (copy_left_r == 5'd1) || done_now;

  // next-state and RAM port control
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    wr_pos_nxt     = wr_pos_r;
    rd_addr_nxt    = rd_addr_r;
    flag_shift_nxt = flag_shift_r;
    phase_nxt      = phase_r;
    off_low_nxt    = off_low_r;
    remain_nxt     = remain_r;
    finished_nxt   = finished_r;
    copy_left_nxt  = copy_left_r;
    fwd_nxt        = fwd_r;
    fwd_data_nxt   = fwd_data_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    mem_we         = 1'b0;
    mem_wa         = wr_pos_r;
    mem_wd         = 8'd0;
    rd_en          = 1'b0;
    mem_ra         = rd_addr_r;
    in_tready      = 1'b0;

    // output register drains
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = win_inc(clr_addr_r);
        if (clr_addr_r == WIN_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = !lit_emit || out_free;
        if (in_tvalid && in_tready && !finished_r) begin
          case (phase_r)
            PH_FIRST: begin
              if (flag_shift_r[0]) begin
                // literal goes straight out and into the window
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = in_tdata;
                out_last_nxt   = 1'b1;
                out_done_nxt   = done_now;
                mem_we         = 1'b1;
                mem_wd         = in_tdata;
                wr_pos_nxt     = win_inc(wr_pos_r);
                remain_nxt     = rem_dec;
                finished_nxt   = done_now;
                flag_shift_nxt = flag_sh;
                phase_nxt      = flag_sh[8] ? PH_FIRST : PH_FLAG;
              end else begin
                off_low_nxt = in_tdata;
                phase_nxt   = PH_SECOND;
              end
            end
            PH_SECOND: begin
              // first window read of the match
              rd_en         = 1'b1;
              mem_ra        = win_mod({in_tdata[7:4], off_low_r});
              rd_addr_nxt   = win_inc(mem_ra);
              copy_left_nxt = {1'b0, in_tdata[3:0]} + MATCH_MIN;
              state_nxt     = ST_COPY;
            end
            default: begin
              flag_shift_nxt = FLAG_FILL | {8'd0, in_tdata};
              phase_nxt      = PH_FIRST;
            end
          endcase
        end
      end

      ST_COPY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_byte;
          out_last_nxt  = copy_end;
          out_done_nxt  = done_now;
          mem_we        = 1'b1;
          mem_wd        = copy_byte;
          wr_pos_nxt    = win_inc(wr_pos_r);
          remain_nxt    = rem_dec;
          finished_nxt  = done_now;
          copy_left_nxt = copy_left_r - 5'd1;
          if (copy_end) begin
            state_nxt      = ST_IDLE;
            flag_shift_nxt = flag_sh;
            phase_nxt      = flag_sh[8] ? PH_FIRST : PH_FLAG;
          end else begin
            rd_en       = 1'b1;
            mem_ra      = rd_addr_r;
            rd_addr_nxt = win_inc(rd_addr_r);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // forward a byte written to the entry being read in the same cycle
    if (rd_en) begin
      fwd_nxt      = mem_we && (mem_ra == mem_wa);
      fwd_data_nxt = mem_wd;
    end

    // length register write reloads the down-counter
    if (cfg_valid) begin
      remain_nxt   = cfg_data;
      finished_nxt = (cfg_data == 32'd0);
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      wr_pos_r     <= WP_INIT;
      rd_addr_r    <= '0;
      flag_shift_r <= 16'd0;
      phase_r      <= PH_FLAG;
      off_low_r    <= 8'd0;
      remain_r     <= 32'd1;
      finished_r   <= 1'b0;
      copy_left_r  <= 5'd0;
      fwd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      wr_pos_r     <= wr_pos_nxt;
      rd_addr_r    <= rd_addr_nxt;
      flag_shift_r <= flag_shift_nxt;
      phase_r      <= phase_nxt;
      off_low_r    <= off_low_nxt;
      remain_r     <= remain_nxt;
      finished_r   <= finished_nxt;
      copy_left_r  <= copy_left_nxt;
      fwd_r        <= fwd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    fwd_data_r <= fwd_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  // history window, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= window_mem[mem_ra];
    end
  end

  // a completing byte always closes its run
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("stream done without last of run");

  // a match in progress always has bytes left to copy
  a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY |-> copy_left_r != 5'd0)
    else $error("copy state with empty count");

  // an exhausted counter means the stream is closed
  a_remain_finished: assert property (@(posedge clk) disable iff (!rst_n)
    remain_r == 32'd0 |-> finished_r)
    else $error("byte counter at zero but stream open");

  // reads that overlap a write only happen inside a match copy
  a_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && rd_en |-> state_r == ST_COPY)
    else $error("window read and write overlap outside copy");

endmodule
